// ===== src/mved_pkg.sv =====
// ----------------------------------------------------------------------------
// mved_pkg: shared types and constants for the mesh vertex/edge dedup block
// Store sizes, field widths, packed stream payloads and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package mved_pkg;

  localparam int VERTICES   = 1024;
  localparam int EDGES      = 4096;
  localparam int COORD_BITS = 24;

  localparam int VIDX_W = $clog2(VERTICES);
  localparam int VCNT_W = $clog2(VERTICES + 1);
  localparam int EIDX_W = $clog2(EDGES);
  localparam int ECNT_W = $clog2(EDGES + 1);
  localparam int RSQ_W  = 2 * COORD_BITS;

  localparam int IN_W      = 9 * COORD_BITS;
  localparam int IN_DATA_W = ((IN_W + 7) / 8) * 8;

  localparam int OUT_W      = 3 * VIDX_W + 2 + 2 + VCNT_W + ECNT_W + RSQ_W + 2;
  localparam int OUT_DATA_W = ((OUT_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_W;

  // Input triangle, first field in the lowest bits; nine coordinates fill
  // whole bytes, so there is no pad.
  typedef struct packed {
    logic [COORD_BITS-1:0]    cz;
    logic [COORD_BITS-1:0]    cy;
    logic [COORD_BITS-1:0]    cx;
    logic [COORD_BITS-1:0]    bz;
    logic [COORD_BITS-1:0]    by;
    logic [COORD_BITS-1:0]    bx;
    logic [COORD_BITS-1:0]    az;
    logic [COORD_BITS-1:0]    ay;
    logic [COORD_BITS-1:0]    ax;
  } mved_in_t;

  // Result item, first field in the lowest bits.
  typedef struct packed {
    logic [OUT_PAD_W-1:0] pad;
    logic [1:0]           full_flags;
    logic [RSQ_W-1:0]     max_radius_sq;
    logic [ECNT_W-1:0]    edge_total;
    logic [VCNT_W-1:0]    vertex_total;
    logic [1:0]           added_edges;
    logic [1:0]           added_vertices;
    logic [VIDX_W-1:0]    index_third;
    logic [VIDX_W-1:0]    index_second;
    logic [VIDX_W-1:0]    index_first;
  } mved_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VSCAN,
    ST_RAD,
    ST_PEAK,
    ST_ESCAN,
    ST_DONE
  } mved_state_e;

endpackage

`default_nettype wire

// ===== src/mesh_vertex_edge_dedup.sv =====
// ----------------------------------------------------------------------------
// mesh_vertex_edge_dedup: vertex welding and edge dedup for indexed meshes
// Looks up each triangle corner in a vertex store, appends new vertices,
// tracks the peak squared radius, then dedups the three undirected edges.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake                     Payload
//  s_axis    in   s_axis_tvalid_i/tready_o      triangle: ax..cz, 24 b each
//  m_axis    out  m_axis_tvalid_o/tready_i      indices, counts, peak, flags
//
//  Each corner lookup scans the vertex memory and each edge lookup the edge
//  memory linearly, one entry per cycle; a hit ends the lookup early. A new
//  vertex also passes through the shared squaring multiplier. Reset empties
//  both stores at once (counts to zero, no clearing pass). A stalled result
//  is held in the output register while the next triangle is accepted and
//  processed.
// ----------------------------------------------------------------------------
`default_nettype none

module mesh_vertex_edge_dedup
  import mved_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // ax, ay, az, bx, by, bz, cx, cy, cz (24 b each, lowest first)
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  // index_first, index_second, index_third, added_vertices, added_edges,
  // vertex_total, edge_total, max_radius_sq, full_flags, zero pad
  output logic [OUT_DATA_W-1:0]      m_axis_tdata_o
);

  localparam int VWORD_W = 3 * COORD_BITS;
  localparam int EWORD_W = 2 * VIDX_W;

  // Storage: packed {z,y,x} vertices and {b,a} edges.
  logic [VWORD_W-1:0] vmem [VERTICES];
  logic [EWORD_W-1:0] emem [EDGES];
  logic [VWORD_W-1:0] vrd_q;
  logic [EWORD_W-1:0] erd_q;

  mved_state_e state_q, state_d;

  mved_in_t           tri_q;
  logic [1:0]         corner_q, corner_d;
  logic [ECNT_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic               cmp_vld_q, cmp_vld_d;
  logic [EIDX_W-1:0]  cmp_idx_q, cmp_idx_d;
  logic [VIDX_W-1:0]  idx_q [3];
  logic [VIDX_W-1:0]  idx_d [3];
  logic [1:0]         new_v_q, new_v_d;
  logic [1:0]         new_e_q, new_e_d;
  logic [1:0]         flags_q, flags_d;
  logic               skip_q, skip_d;
  logic [VCNT_W-1:0]  vcnt_q, vcnt_d;
  logic [ECNT_W-1:0]  ecnt_q, ecnt_d;
  logic [RSQ_W-1:0]   peak_q, peak_d;
  logic [1:0]         step_q, step_d;
  logic [RSQ_W-1:0]   prod_q, prod_d;
  logic [RSQ_W-1:0]   acc_q, acc_d;
  mved_out_t          out_q, out_d;
  logic               out_vld_q, out_vld_d;

  // Current corner and edge endpoints.
  logic [COORD_BITS-1:0] cur_x, cur_y, cur_z;
  logic [VIDX_W-1:0]     ep_p, ep_q;
  logic [COORD_BITS-1:0] mul_in;
  logic [COORD_BITS-1:0] mul_abs;

  // Shared scan outcome.
  logic scan_end, v_hit, e_hit;
  logic v_full, e_full;

  // Memory write ports.
  logic              vwe, ewe;
  logic [VIDX_W-1:0] vwaddr;
  logic [EIDX_W-1:0] ewaddr;

  logic in_xfer, out_free;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_q;

  always_comb begin
    case (corner_q)
      2'd0:    begin cur_x = tri_q.ax; cur_y = tri_q.ay; cur_z = tri_q.az; end
      2'd1:    begin cur_x = tri_q.bx; cur_y = tri_q.by; cur_z = tri_q.bz; end
      default: begin cur_x = tri_q.cx; cur_y = tri_q.cy; cur_z = tri_q.cz; end
    endcase
  end

  // Edge i runs from corner i to corner i+1 mod 3.
  always_comb begin
    case (corner_q)
      2'd0:    begin ep_p = idx_q[0]; ep_q = idx_q[1]; end
      2'd1:    begin ep_p = idx_q[1]; ep_q = idx_q[2]; end
      default: begin ep_p = idx_q[2]; ep_q = idx_q[0]; end
    endcase
  end

  // Squaring operand: x, y, z on successive steps; magnitude fits unsigned.
  always_comb begin
    case (step_q)
      2'd0:    mul_in = cur_x;
      2'd1:    mul_in = cur_y;
      default: mul_in = cur_z;
    endcase
    mul_abs = mul_in[COORD_BITS-1] ? (~mul_in + 1'b1) : mul_in;
  end

  assign scan_end = (state_q == ST_VSCAN) ? (rd_ptr_q == ECNT_W'(vcnt_q))
                                          : (rd_ptr_q == ecnt_q);
  assign v_hit    = cmp_vld_q && (vrd_q == {cur_z, cur_y, cur_x});
  assign e_hit    = cmp_vld_q &&
                    ((erd_q == {ep_q, ep_p}) || (erd_q == {ep_p, ep_q}));
  assign v_full   = (vcnt_q == VCNT_W'(VERTICES));
  assign e_full   = (ecnt_q == ECNT_W'(EDGES));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) state_d = ST_VSCAN;
      end
      ST_VSCAN: begin
        if (v_hit || (scan_end && v_full)) begin
          if (corner_q != 2'd2) state_d = ST_VSCAN;
          else if (skip_q || v_hit == 1'b0) state_d = ST_DONE;
          else state_d = ST_ESCAN;
          if (corner_q == 2'd2 && v_hit) state_d = skip_q ? ST_DONE : ST_ESCAN;
        end else if (scan_end) begin
          state_d = ST_RAD;
        end
      end
      ST_RAD: begin
        if (step_q == 2'd3) state_d = ST_PEAK;
      end
      ST_PEAK: begin
        if (corner_q != 2'd2) state_d = ST_VSCAN;
        else state_d = skip_q ? ST_DONE : ST_ESCAN;
      end
      ST_ESCAN: begin
        if ((e_hit || scan_end) && corner_q == 2'd2) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs of the sequencer.
  always_comb begin
    corner_d  = corner_q;
    rd_ptr_d  = rd_ptr_q;
    cmp_vld_d = cmp_vld_q;
    cmp_idx_d = cmp_idx_q;
    idx_d     = idx_q;
    new_v_d   = new_v_q;
    new_e_d   = new_e_q;
    flags_d   = flags_q;
    skip_d    = skip_q;
    vcnt_d    = vcnt_q;
    ecnt_d    = ecnt_q;
    peak_d    = peak_q;
    step_d    = step_q;
    prod_d    = prod_q;
    acc_d     = acc_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && !m_axis_tready_i;
    vwe       = 1'b0;
    ewe       = 1'b0;
    vwaddr    = vcnt_q[VIDX_W-1:0];
    ewaddr    = ecnt_q[EIDX_W-1:0];

    unique case (state_q)
      ST_IDLE: begin
        corner_d  = 2'd0;
        rd_ptr_d  = '0;
        cmp_vld_d = 1'b0;
        new_v_d   = '0;
        new_e_d   = '0;
        flags_d   = '0;
        skip_d    = 1'b0;
      end
      ST_VSCAN: begin
        if (v_hit) begin
          idx_d[corner_q] = cmp_idx_q[VIDX_W-1:0];
          corner_d  = (corner_q == 2'd2) ? 2'd0 : corner_q + 2'd1;
          rd_ptr_d  = '0;
          cmp_vld_d = 1'b0;
        end else if (scan_end) begin
          rd_ptr_d  = '0;
          cmp_vld_d = 1'b0;
          if (v_full) begin
            // Store full: index 0, flag it, drop the edges of this triangle.
            idx_d[corner_q] = '0;
            flags_d[0]      = 1'b1;
            skip_d          = 1'b1;
            corner_d        = (corner_q == 2'd2) ? 2'd0 : corner_q + 2'd1;
          end else begin
            vwe             = 1'b1;
            idx_d[corner_q] = vcnt_q[VIDX_W-1:0];
            vcnt_d          = vcnt_q + 1'b1;
            new_v_d         = new_v_q + 2'd1;
            step_d          = 2'd0;
            acc_d           = '0;
          end
        end else begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = rd_ptr_q[EIDX_W-1:0];
          rd_ptr_d  = rd_ptr_q + 1'b1;
        end
      end
      ST_RAD: begin
        // Multiply on steps 0..2, accumulate the previous product on 1..3.
        if (step_q != 2'd3) prod_d = RSQ_W'(mul_abs) * RSQ_W'(mul_abs);
        if (step_q != 2'd0) acc_d = acc_q + prod_q;
        step_d = step_q + 2'd1;
      end
      ST_PEAK: begin
        if (acc_q > peak_q) peak_d = acc_q;
        corner_d = (corner_q == 2'd2) ? 2'd0 : corner_q + 2'd1;
      end
      ST_ESCAN: begin
        if (e_hit || scan_end) begin
          if (!e_hit) begin
            if (e_full) begin
              flags_d[1] = 1'b1;
            end else begin
              ewe     = 1'b1;
              ecnt_d  = ecnt_q + 1'b1;
              new_e_d = new_e_q + 2'd1;
            end
          end
          corner_d  = (corner_q == 2'd2) ? 2'd0 : corner_q + 2'd1;
          rd_ptr_d  = '0;
          cmp_vld_d = 1'b0;
        end else begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = rd_ptr_q[EIDX_W-1:0];
          rd_ptr_d  = rd_ptr_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_vld_d            = 1'b1;
          out_d.pad            = '0;
          out_d.full_flags     = flags_q;
          out_d.max_radius_sq  = peak_q;
          out_d.edge_total     = ecnt_q;
          out_d.vertex_total   = vcnt_q;
          out_d.added_edges    = new_e_q;
          out_d.added_vertices = new_v_q;
          out_d.index_third    = idx_q[2];
          out_d.index_second   = idx_q[1];
          out_d.index_first    = idx_q[0];
        end
      end
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      vcnt_q    <= '0;
      ecnt_q    <= '0;
      peak_q    <= '0;
      out_vld_q <= 1'b0;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      vcnt_q    <= vcnt_d;
      ecnt_q    <= ecnt_d;
      peak_q    <= peak_d;
      out_vld_q <= out_vld_d;
      cmp_vld_q <= cmp_vld_d;
    end
  end

  // Payload and scan registers.
  always_ff @(posedge clk_i) begin
    if (in_xfer) tri_q <= mved_in_t'(s_axis_tdata_i);
    corner_q  <= corner_d;
    rd_ptr_q  <= rd_ptr_d;
    cmp_idx_q <= cmp_idx_d;
    idx_q     <= idx_d;
    new_v_q   <= new_v_d;
    new_e_q   <= new_e_d;
    flags_q   <= flags_d;
    skip_q    <= skip_d;
    step_q    <= step_d;
    prod_q    <= prod_d;
    acc_q     <= acc_d;
    out_q     <= out_d;
  end

  // Vertex store: one write, one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (vwe) vmem[vwaddr] <= {cur_z, cur_y, cur_x};
    vrd_q <= vmem[rd_ptr_q[VIDX_W-1:0]];
  end

  // Edge store: one write, one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (ewe) emem[ewaddr] <= {ep_q, ep_p};
    erd_q <= emem[rd_ptr_q[EIDX_W-1:0]];
  end

endmodule

`default_nettype wire

// ===== src/mved_checker.sv =====
// ----------------------------------------------------------------------------
// mved_checker: port-level checks for the mesh vertex/edge dedup block
// Watches result stalls and consistency, and input ready after a transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module mved_checker
  import mved_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_axis_tvalid_i,
  input wire logic                  s_axis_tready_o,
  input wire logic                  m_axis_tvalid_o,
  input wire logic                  m_axis_tready_i,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  mved_out_t res;
  assign res = mved_out_t'(m_axis_tdata_o);

  // Hold a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  // Every returned index names a stored vertex (or is 0 on a full store).
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      (VCNT_W'(res.index_first) < res.vertex_total) &&
      (VCNT_W'(res.index_second) < res.vertex_total) &&
      (VCNT_W'(res.index_third) < res.vertex_total))
    else $error("vertex index beyond vertex total");

  // A vertex store overflow skips all edges of that triangle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && res.full_flags[0] |-> res.added_edges == 2'd0 &&
      res.vertex_total == VCNT_W'(VERTICES))
    else $error("edges added on vertex overflow");

  // An edge overflow only happens with a full edge store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && res.full_flags[1] |-> res.edge_total == ECNT_W'(EDGES))
    else $error("edge overflow below capacity");

  // One triangle at a time: drop ready right after an input transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input ready after a transfer");

endmodule

bind mesh_vertex_edge_dedup mved_checker u_mved_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire
